FILE: rtl/wrapped_bilinear_noise_sampler_macros.svh
// ---------------------------------------------------------------------------
// Wrapped bilinear noise sampler: assertion macros
// Concurrent assertion shorthands on clk, with rst disabling the check.
// ---------------------------------------------------------------------------
`ifndef WRAPPED_BILINEAR_NOISE_SAMPLER_MACROS_SVH
`define WRAPPED_BILINEAR_NOISE_SAMPLER_MACROS_SVH

// same-cycle implication
`define WBNS_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wbns: same-cycle check failed");

// next-cycle implication
`define WBNS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wbns: next-cycle check failed");

`endif

FILE: rtl/wbns_pkg.sv
// ---------------------------------------------------------------------------
// Wrapped bilinear noise sampler: package
// Port types, register indices and command codes.
// ---------------------------------------------------------------------------
package wbns_pkg;

  typedef logic signed [31:0] coord_t;
  typedef logic [7:0]         idx_t;
  typedef logic [7:0]         byte_t;
  typedef logic signed [16:0] noise_t;
  typedef logic [31:0]        cfg_data_t;

  typedef enum logic [1:0] {
    CFG_SCALE  = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_t;

  localparam logic [8:0]  TBL_DIM     = 9'd256;
  localparam int          MEM_DEPTH   = 65536;
  localparam logic [31:0] SCALE_RESET = 32'd65536;
  localparam logic [24:0] RECIP_255   = 25'd16843010;
  localparam logic [39:0] ROUND_BIAS  = 40'd8355840;
  localparam logic [16:0] NOISE_OFS   = 17'd32768;

endpackage

FILE: rtl/wrapped_bilinear_noise_sampler.sv
// ---------------------------------------------------------------------------
// Wrapped bilinear noise sampler
// Byte noise table with wrapped bilinear lookup, result in signed Q1.15.
// ---------------------------------------------------------------------------
// A write command (func low) stores one table byte in the cycle it is taken
// and keeps busy low. A sample command (func high) raises busy and then
// shows noise_value for one cycle under done; the next command may be
// taken in that same cycle. The sample runs through the single bit-serial
// restoring divider: 64 steps for each coordinate divided by the scale, then
// table reads of the four corners through the one read port, interpolation
// on one shared multiplier, a reciprocal multiplication for the final
// mapping to Q1.15 and a last state to present the beat. The receiver cannot
// stall: done lasts one cycle only.
// Configuration writes are always taken (cfg_ready stays high) and must only
// be issued while busy is low. Table entries read before being written give
// an undefined result.
module wrapped_bilinear_noise_sampler (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 func,
  input  wbns_pkg::coord_t     coord_x,
  input  wbns_pkg::coord_t     coord_z,
  input  wbns_pkg::idx_t       write_row,
  input  wbns_pkg::idx_t       write_col,
  input  wbns_pkg::byte_t      write_byte,
  output logic                 done,
  output wbns_pkg::noise_t     noise_value,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  wbns_pkg::cfg_data_t  cfg_data
);
  import wbns_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_DIVX = 11'b000_0000_0010,
    S_DIVZ = 11'b000_0000_0100,
    S_READ = 11'b000_0000_1000,
    S_MUL1 = 11'b000_0001_0000,
    S_MUL2 = 11'b000_0010_0000,
    S_MUL3 = 11'b000_0100_0000,
    S_MUL4 = 11'b000_1000_0000,
    S_LOAD = 11'b001_0000_0000,
    S_MAP  = 11'b010_0000_0000,
    S_DONE = 11'b100_0000_0000
  } state_t;

  state_t             state;
  logic [31:0]        scale_q16;
  logic [8:0]         table_width;
  logic [8:0]         table_height;
  logic [8:0]         width_c;
  logic [8:0]         height_c;

  logic [63:0]        dvd;
  logic [31:0]        rem;
  logic [31:0]        dsr;
  logic [15:0]        quo;
  logic [7:0]         acc;
  logic [5:0]         cnt;
  logic [31:0]        az;
  logic [31:0]        abs_x;
  logic [31:0]        abs_z;

  logic [32:0]        rsh;
  logic               ge;
  logic [32:0]        rem_next;
  logic [15:0]        quo_next;
  logic [8:0]         acc_sh;
  logic [8:0]         mod_w;
  logic [7:0]         acc_next;

  logic [7:0]         x0;
  logic [7:0]         z0;
  logic [7:0]         x1;
  logic [7:0]         z1;
  logic [8:0]         x0_inc;
  logic [8:0]         z0_inc;
  logic [15:0]        tx;
  logic [15:0]        tz;

  logic [7:0]         mem [MEM_DEPTH];
  logic [15:0]        raddr;
  logic [7:0]         rdata;
  logic               wr_en;
  logic [7:0]         corner [4];
  logic [1:0]         cidx;

  logic signed [16:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [41:0] mul_p;
  logic signed [41:0] prod;
  logic signed [41:0] base;
  logic signed [41:0] lin_sum;
  logic [8:0]         dq0;
  logic [8:0]         dq1;
  logic [24:0]        dr;
  logic [23:0]        r1;
  logic [23:0]        r2;
  logic [39:0]        fin_dvd;
  logic [23:0]        fin_m;
  logic [48:0]        recip_p;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign wr_en     = start && !busy && (func == FUNC_WRITE);

  assign width_c  = (table_width == 9'd0) ? 9'd1 :
                    (table_width > TBL_DIM) ? TBL_DIM : table_width;
  assign height_c = (table_height == 9'd0) ? 9'd1 :
                    (table_height > TBL_DIM) ? TBL_DIM : table_height;

  assign abs_x = coord_x[31] ? (~$unsigned(coord_x) + 32'd1) : $unsigned(coord_x);
  assign abs_z = coord_z[31] ? (~$unsigned(coord_z) + 32'd1) : $unsigned(coord_z);

  assign rsh      = {rem, dvd[63]};
  assign ge       = (rsh >= {1'b0, dsr});
  assign rem_next = ge ? (rsh - {1'b0, dsr}) : rsh;
  assign quo_next = {quo[14:0], ge};
  assign mod_w    = (state == S_DIVX) ? width_c : height_c;
  assign acc_sh   = {acc, ge};
  assign acc_next = (acc_sh >= mod_w) ? 8'(acc_sh - mod_w) : acc_sh[7:0];

  assign x0_inc = {1'b0, x0} + 9'd1;
  assign z0_inc = {1'b0, z0} + 9'd1;
  assign x1     = (x0_inc == width_c) ? 8'd0 : x0_inc[7:0];
  assign z1     = (z0_inc == height_c) ? 8'd0 : z0_inc[7:0];
  assign raddr  = {(cnt[1] ? x1 : x0), (cnt[0] ? z1 : z0)};
  assign cidx   = 2'(cnt[2:0] - 3'd1);

  assign dq0 = {1'b0, corner[2]} - {1'b0, corner[0]};
  assign dq1 = {1'b0, corner[3]} - {1'b0, corner[1]};
  assign dr  = {1'b0, r2} - {1'b0, r1};

  always_comb begin
    mul_a = $signed({1'b0, tx});
    mul_b = $signed({{16{dq0[8]}}, dq0});
    base  = $signed({18'd0, corner[0], 16'd0});
    case (state)
      S_MUL2: begin
        mul_b = $signed({{16{dq1[8]}}, dq1});
      end
      S_MUL3: begin
        base = $signed({18'd0, corner[1], 16'd0});
      end
      S_MUL4: begin
        mul_a = $signed({1'b0, tz});
        mul_b = $signed(dr);
      end
      S_LOAD: begin
        base = $signed({2'd0, r1, 16'd0});
      end
      default: begin
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign lin_sum = base + prod;
  assign fin_dvd = lin_sum[39:0] + ROUND_BIAS;
  assign recip_p = {25'd0, fin_m} * {24'd0, RECIP_255};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{write_row, write_col}] <= write_byte;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_q16    <= SCALE_RESET;
      table_width  <= TBL_DIM;
      table_height <= TBL_DIM;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SCALE:  scale_q16    <= cfg_data;
        CFG_WIDTH:  table_width  <= cfg_data[8:0];
        CFG_HEIGHT: table_height <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == S_DONE);
      case (state)
        S_IDLE: begin
          if (start && (func == FUNC_SAMPLE)) begin
            dvd   <= {abs_x, 32'd0};
            az    <= abs_z;
            rem   <= 32'd0;
            acc   <= 8'd0;
            cnt   <= 6'd63;
            dsr   <= (scale_q16 == 32'd0) ? 32'd1 : scale_q16;
            state <= S_DIVX;
          end
        end
        S_DIVX, S_DIVZ: begin
          quo <= quo_next;
          if (cnt == 6'd0) begin
            rem <= 32'd0;
            acc <= 8'd0;
            if (state == S_DIVX) begin
              x0    <= acc;
              tx    <= quo_next;
              dvd   <= {az, 32'd0};
              cnt   <= 6'd63;
              state <= S_DIVZ;
            end else begin
              z0    <= acc;
              tz    <= quo_next;
              cnt   <= 6'd0;
              state <= S_READ;
            end
          end else begin
            dvd <= {dvd[62:0], 1'b0};
            rem <= rem_next[31:0];
            if (|cnt[5:4]) begin
              acc <= acc_next;
            end
            cnt <= cnt - 6'd1;
          end
        end
        S_READ: begin
          if (cnt[2:0] != 3'd0) begin
            corner[cidx] <= rdata;
          end
          if (cnt[2:0] == 3'd4) begin
            state <= S_MUL1;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_MUL1: begin
          prod  <= mul_p;
          state <= S_MUL2;
        end
        S_MUL2: begin
          r1    <= lin_sum[23:0];
          prod  <= mul_p;
          state <= S_MUL3;
        end
        S_MUL3: begin
          r2    <= lin_sum[23:0];
          state <= S_MUL4;
        end
        S_MUL4: begin
          prod  <= mul_p;
          state <= S_LOAD;
        end
        S_LOAD: begin
          fin_m <= fin_dvd[39:16];
          state <= S_MAP;
        end
        S_MAP: begin
          noise_value <= $signed(recip_p[48:32] - NOISE_OFS);
          state       <= S_DONE;
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/wbns_checker.sv
// ---------------------------------------------------------------------------
// Wrapped bilinear noise sampler: port checker
// Watches the command and result ports of the sampler over time.
// ---------------------------------------------------------------------------
`include "wrapped_bilinear_noise_sampler_macros.svh"

module wbns_port_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic func,
  input logic done
);
  import wbns_pkg::*;

  `WBNS_ASSERT_NOW(a_done_idle, done, !busy)
  `WBNS_ASSERT_NEXT(a_sample_busy, start && !busy && (func == FUNC_SAMPLE), busy)
  `WBNS_ASSERT_NEXT(a_write_quiet, start && !busy && (func == FUNC_WRITE), !busy && !done)
  `WBNS_ASSERT_NEXT(a_done_pulse, done, !done)

endmodule

bind wrapped_bilinear_noise_sampler wbns_port_checker u_wbns_port_checker (.*);

FILE: sim/wbns_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Noise sampler checker
// Watches the command, configuration and result channels. Keeps a shadow of
// the noise table and registers, predicts each sample's Q1.15 value and
// compares it with what arrives under done.
// ---------------------------------------------------------------------------
module wbns_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic                 func,
  input  wbns_pkg::coord_t     coord_x,
  input  wbns_pkg::coord_t     coord_z,
  input  wbns_pkg::idx_t       write_row,
  input  wbns_pkg::idx_t       write_col,
  input  wbns_pkg::byte_t      write_byte,
  input  logic                 done,
  input  wbns_pkg::noise_t     noise_value,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  wbns_pkg::cfg_data_t  cfg_data,
  output int                   fail_count,
  output int                   pending
);
  import wbns_pkg::*;

  logic [31:0] scale_reg;
  logic [8:0]  width_reg;
  logic [8:0]  height_reg;
  byte_t       shadow_tbl [MEM_DEPTH];
  noise_t      noise_due [$];
  int          fails = 0;
  int          outstanding = 0;

  assign fail_count = fails;
  assign pending    = outstanding;

  initial begin
    for (int i = 0; i < MEM_DEPTH; i++) shadow_tbl[i] = '0;
  end

  function automatic int unsigned fold_dim(logic [8:0] d);
    if (d == 9'd0) return 1;
    if (d > TBL_DIM) return 256;
    return int'(d);
  endfunction

  function automatic noise_t predict_noise(coord_t cx, coord_t cz);
    logic [31:0]     mag_x, mag_z;
    longint unsigned divisor, qx, qz;
    int unsigned     w, h, x0, x1, z0, z1;
    longint          tx, tz, c00, c01, c10, c11, r1, r2, acc, val;
    mag_x   = cx[31] ? ~cx + 32'd1 : cx;
    mag_z   = cz[31] ? ~cz + 32'd1 : cz;
    divisor = (scale_reg == 32'd0) ? 64'd1 : {32'd0, scale_reg};
    qx      = {mag_x, 32'd0} / divisor;
    qz      = {mag_z, 32'd0} / divisor;
    w  = fold_dim(width_reg);
    h  = fold_dim(height_reg);
    x0 = 32'((qx >> 16) % w);
    z0 = 32'((qz >> 16) % h);
    x1 = (x0 + 1) % w;
    z1 = (z0 + 1) % h;
    tx = {48'd0, qx[15:0]};
    tz = {48'd0, qz[15:0]};
    c00 = {56'd0, shadow_tbl[{x0[7:0], z0[7:0]}]};
    c01 = {56'd0, shadow_tbl[{x0[7:0], z1[7:0]}]};
    c10 = {56'd0, shadow_tbl[{x1[7:0], z0[7:0]}]};
    c11 = {56'd0, shadow_tbl[{x1[7:0], z1[7:0]}]};
    r1  = c00 * 65536 + tx * (c10 - c00);
    r2  = c01 * 65536 + tx * (c11 - c01);
    acc = r1 * 65536 + tz * (r2 - r1);
    val = (acc + 64'sd8355840) / 64'sd16711680 - 64'sd32768;
    return noise_t'(val[16:0]);
  endfunction

  always @(posedge clk) begin : watch
    noise_t want;
    if (rst) begin
      scale_reg  <= SCALE_RESET;
      width_reg  <= TBL_DIM;
      height_reg <= TBL_DIM;
      noise_due.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SCALE:  scale_reg  <= cfg_data;
          CFG_WIDTH:  width_reg  <= cfg_data[8:0];
          CFG_HEIGHT: height_reg <= cfg_data[8:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (func == FUNC_WRITE)
          shadow_tbl[{write_row, write_col}] <= write_byte;
        else
          noise_due.push_back(predict_noise(coord_x, coord_z));
      end
      if (done) begin
        if (noise_due.size() == 0) begin
          fails++;
          $display("%0t: unexpected noise_value beat, expected none, actual %0d",
                   $time, noise_value);
        end else begin
          want = noise_due.pop_front();
          if (noise_value !== want) begin
            fails++;
            $display("%0t: noise_value mismatch, expected %0d, actual %0d",
                     $time, want, noise_value);
          end
        end
      end
      outstanding <= noise_due.size();
    end
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Noise sampler testbench
// Drives table writes, sample commands and register writes with random
// gaps. Every table entry a sample will touch is written first. A directed
// opening covers the value extremes and the wrap corners; eight register
// settings then follow with random traffic. The checker does the comparing.
// ---------------------------------------------------------------------------
module tb;
  import wbns_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 90;

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       start      = 1'b0;
  logic       busy;
  logic       func       = 1'b0;
  coord_t     coord_x    = '0;
  coord_t     coord_z    = '0;
  idx_t       write_row  = '0;
  idx_t       write_col  = '0;
  byte_t      write_byte = '0;
  logic       done;
  noise_t     noise_value;
  logic       cfg_valid  = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index  = CFG_SCALE;
  cfg_data_t  cfg_data   = '0;
  int         fail_count;
  int         pending;

  bit          wrote [MEM_DEPTH];
  logic [31:0] cur_scale = SCALE_RESET;
  int unsigned cur_w     = 256;
  int unsigned cur_h     = 256;
  bit          quiet     = 1'b0;
  int          items_sent = 0;
  int          idle_cycles = 0;

  wrapped_bilinear_noise_sampler dut (.*);
  wbns_checker chk (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic byte_t rand_byte();
    return byte_t'($urandom_range(0, 255));
  endfunction

  function automatic coord_t pick_coord();
    coord_t v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       v = 32'sd0;
          1:       v = 32'sd1;
          2:       v = -32'sd1;
          3:       v = 32'h7FFF_FFFF;
          default: v = 32'h8000_0000;
        endcase
      end
      1, 2, 3: v = coord_t'($urandom);
      default: begin
        v = coord_t'($urandom_range(0, 5000));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_scale();
    logic [31:0] s;
    s = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(1, 32'h0010_0000);
    if (s == 32'd0) s = 32'd1;
    return s;
  endfunction

  function automatic int unsigned wrap_base(coord_t c, logic [31:0] sc, int unsigned dim);
    logic [31:0]     mag;
    longint unsigned q;
    mag = c[31] ? ~c + 32'd1 : c;
    q   = {mag, 32'd0} / {32'd0, sc};
    return 32'((q >> 16) % dim);
  endfunction

  task automatic issue(input func_t f, input coord_t x, input coord_t z,
                       input idx_t r, input idx_t c, input byte_t b);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    func       <= f;
    coord_x    <= x;
    coord_z    <= z;
    write_row  <= r;
    write_col  <= c;
    write_byte <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (f == FUNC_WRITE) wrote[{r, c}] = 1'b1;
  endtask

  task automatic fill(input idx_t r, input idx_t c);
    if (!wrote[{r, c}])
      issue(FUNC_WRITE, pick_coord(), pick_coord(), r, c, rand_byte());
  endtask

  // write any corner the sample will read that holds nothing yet, then issue the sample
  task automatic sample_at(input coord_t x, input coord_t z);
    int unsigned x0, x1, z0, z1;
    x0 = wrap_base(x, cur_scale, cur_w);
    z0 = wrap_base(z, cur_scale, cur_h);
    x1 = (x0 + 1) % cur_w;
    z1 = (z0 + 1) % cur_h;
    fill(idx_t'(x0), idx_t'(z0));
    fill(idx_t'(x0), idx_t'(z1));
    fill(idx_t'(x1), idx_t'(z0));
    fill(idx_t'(x1), idx_t'(z1));
    issue(FUNC_SAMPLE, x, z, rand_byte(), rand_byte(), rand_byte());
  endtask

  // hold commands until every sample has returned
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input cfg_idx_t idx, input cfg_data_t val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SCALE:  cur_scale = val;
      CFG_WIDTH:  cur_w     = val[8:0];
      CFG_HEIGHT: cur_h     = val[8:0];
      default: ;
    endcase
  endtask

  initial begin
    int base;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    issue(FUNC_WRITE, '0, '0, 8'd0, 8'd0, 8'd0);
    issue(FUNC_WRITE, '0, '0, 8'd0, 8'd1, 8'd0);
    issue(FUNC_WRITE, '0, '0, 8'd1, 8'd0, 8'd0);
    issue(FUNC_WRITE, '0, '0, 8'd1, 8'd1, 8'd0);
    sample_at(32'sd0, 32'sd0);
    issue(FUNC_WRITE, 32'h7FFF_FFFF, 32'h8000_0000, 8'd255, 8'd255, 8'd255);
    issue(FUNC_WRITE, 32'h7FFF_FFFF, 32'h8000_0000, 8'd255, 8'd0, 8'd255);
    issue(FUNC_WRITE, 32'h7FFF_FFFF, 32'h8000_0000, 8'd0, 8'd255, 8'd255);
    issue(FUNC_WRITE, 32'h7FFF_FFFF, 32'h8000_0000, 8'd0, 8'd0, 8'd255);
    sample_at(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    sample_at(32'h8000_0000, -32'sd1);
    issue(FUNC_WRITE, '0, '0, 8'd128, 8'd64, 8'h5A);
    set_reg(CFG_SCALE, 32'h0001_8000);
    sample_at(32'sd1, -32'sd1);
    sample_at(-32'sd3, 32'sd7);
    sample_at(32'h8000_0000, 32'h7FFF_FFFF);
    set_reg(CFG_WIDTH, 32'd3);
    set_reg(CFG_HEIGHT, 32'd2);
    sample_at(32'sd5, -32'sd5);
    sample_at(32'h7FFF_FFFF, 32'h8000_0000);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          set_reg(CFG_SCALE, SCALE_RESET);
          set_reg(CFG_WIDTH, 32'd256);
          set_reg(CFG_HEIGHT, 32'd256);
        end
        1: begin
          set_reg(CFG_SCALE, 32'd1);
          set_reg(CFG_WIDTH, 32'd1);
          set_reg(CFG_HEIGHT, 32'd1);
        end
        2: begin
          set_reg(CFG_SCALE, 32'hFFFF_FFFF);
          set_reg(CFG_WIDTH, 32'd256);
          set_reg(CFG_HEIGHT, 32'd256);
        end
        3: begin
          set_reg(CFG_SCALE, pick_scale());
          set_reg(CFG_WIDTH, 32'd256);
          set_reg(CFG_HEIGHT, 32'd1);
        end
        4: begin
          set_reg(CFG_SCALE, pick_scale());
          set_reg(CFG_WIDTH, 32'd1);
          set_reg(CFG_HEIGHT, 32'd256);
        end
        5: begin
          set_reg(CFG_SCALE, $urandom_range(256, 32'h0004_0000));
          set_reg(CFG_WIDTH, $urandom_range(1, 16));
          set_reg(CFG_HEIGHT, $urandom_range(1, 16));
        end
        6: begin
          set_reg(CFG_SCALE, pick_scale());
          set_reg(CFG_WIDTH, $urandom_range(1, 256));
          set_reg(CFG_HEIGHT, $urandom_range(1, 256));
        end
        default: begin
          set_reg(CFG_SCALE, 32'h0001_8000);
          set_reg(CFG_WIDTH, 32'd255);
          set_reg(CFG_HEIGHT, 32'd7);
        end
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      base  = items_sent;
      while (items_sent - base < PHASE_ITEMS) begin
        if ($urandom_range(0, 39) == 0) settle();
        if ($urandom_range(0, 6) == 0)
          issue(FUNC_WRITE, pick_coord(), pick_coord(), rand_byte(), rand_byte(),
                rand_byte());
        else
          sample_at(pick_coord(), pick_coord());
      end
    end

    settle();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
